// ----- sv/fsgs_pkg.sv -----
// ----------------------------------------------------------------------------
// fsgs_pkg: shared types and constants for the falling-sand grid
// Grid geometry, opcodes, cell codes, register indexes and payload structs.
// ----------------------------------------------------------------------------
package fsgs_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROWN_W = $clog2(MAX_ROWS + 1);
    localparam int COLN_W = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = ROW_W + COL_W;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 2'd1;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [1:0] CELL_BLANK = 2'd0;
    localparam logic [1:0] CELL_SAND  = 2'd1;
    localparam logic [1:0] CELL_WATER = 2'd2;
    localparam logic [1:0] CELL_WOOD  = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] row;
        logic [7:0] col;
        logic [1:0] cell_value;
    } t_item;

    typedef struct packed {
        logic [1:0] read_value;
        logic       address_error;
    } t_result;

endpackage

// ----- sv/falling_sand_grid_step.sv -----
// ----------------------------------------------------------------------------
// falling_sand_grid_step: falling-sand grid with cell access and generation step
// Write, read or advance a grid of sand, water and wood cells.
// ----------------------------------------------------------------------------
// After reset the grid is cleared one cell a cycle, with busy high. An item
// is taken when start is high and busy is low; its single result appears
// on o_result for one cycle with o_result_valid and must be taken then,
// there is no back-pressure. A generation walks every active cell through
// one single-port grid memory with a registered read; a blank, wood or
// just-moved cell is passed over, while a water cell may try all five
// neighbours.
// Size registers may be written at any time the block is idle.
module falling_sand_grid_step
    import fsgs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_result_valid,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_OP    = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_VISIT = 4'd4;
    localparam logic [3:0] S_KIND  = 4'd5;
    localparam logic [3:0] S_CAND  = 4'd6;
    localparam logic [3:0] S_TEST  = 4'd7;
    localparam logic [3:0] S_MOVE  = 4'd8;

    localparam logic [2:0] K_BELOW       = 3'd0;
    localparam logic [2:0] K_BELOW_LEFT  = 3'd1;
    localparam logic [2:0] K_BELOW_RIGHT = 3'd2;
    localparam logic [2:0] K_LEFT        = 3'd3;
    localparam logic [2:0] K_RIGHT       = 3'd4;
    localparam logic [2:0] TRIES_SAND    = 3'd3;
    localparam logic [2:0] TRIES_WATER   = 3'd5;

    logic [1:0]        mem [0:MEM_DEPTH-1];
    logic [1:0]        r_mem_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [1:0]        mem_wd;

    logic [3:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    t_item             r_item, n_item;
    logic [CFG_W-1:0]  r_rows, r_cols;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [2:0]        r_k, n_k;
    logic [1:0]        r_kind, n_kind;
    logic              r_skip, n_skip;
    logic [ADDR_W-1:0] r_dest, n_dest;
    logic              r_res_valid, n_res_valid;
    t_result           r_result, n_result;

    logic [ROWN_W-1:0] nr;
    logic [COLN_W-1:0] nc;
    logic              item_ok;
    logic [ADDR_W-1:0] item_addr;
    logic [ADDR_W-1:0] here_addr;
    logic [ROW_W-1:0]  row_dn;
    logic [COL_W-1:0]  col_l, col_r;
    logic              has_below, has_left, has_right, last_col;
    logic              cand_ok;
    logic [ADDR_W-1:0] cand_addr;
    logic [2:0]        tries;
    logic              accept;
    logic              adv;

    assign nr = (32'(r_rows) > MAX_ROWS) ? ROWN_W'(MAX_ROWS) : ROWN_W'(r_rows);
    assign nc = (32'(r_cols) > MAX_COLS) ? COLN_W'(MAX_COLS) : COLN_W'(r_cols);

    assign item_ok   = (32'(r_item.row) < 32'(nr)) && (32'(r_item.col) < 32'(nc));
    assign item_addr = {ROW_W'(r_item.row), COL_W'(r_item.col)};

    assign here_addr = {r_row, r_col};
    assign row_dn    = r_row + ROW_W'(1);
    assign col_l     = r_col - COL_W'(1);
    assign col_r     = r_col + COL_W'(1);
    assign has_below = (ROWN_W'(r_row) + ROWN_W'(1)) < nr;
    assign has_left  = (r_col != '0);
    assign has_right = (COLN_W'(r_col) + COLN_W'(1)) < nc;
    assign last_col  = (COLN_W'(r_col) + COLN_W'(1)) == nc;

    assign tries  = (r_kind == CELL_SAND) ? TRIES_SAND : TRIES_WATER;
    assign accept = (r_mem_q == CELL_BLANK) ||
                    ((r_kind == CELL_SAND) && (r_mem_q == CELL_WATER));

    always_comb begin
        cand_ok   = 1'b0;
        cand_addr = here_addr;
        unique case (r_k)
            K_BELOW: begin
                cand_ok   = has_below;
                cand_addr = {row_dn, r_col};
            end
            K_BELOW_LEFT: begin
                cand_ok   = has_below && has_left;
                cand_addr = {row_dn, col_l};
            end
            K_BELOW_RIGHT: begin
                cand_ok   = has_below && has_right;
                cand_addr = {row_dn, col_r};
            end
            K_LEFT: begin
                cand_ok   = has_left;
                cand_addr = {r_row, col_l};
            end
            K_RIGHT: begin
                cand_ok   = has_right;
                cand_addr = {r_row, col_r};
            end
            default: begin
                cand_ok   = 1'b0;
                cand_addr = here_addr;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_item      = r_item;
        n_row       = r_row;
        n_col       = r_col;
        n_k         = r_k;
        n_kind      = r_kind;
        n_skip      = r_skip;
        n_dest      = r_dest;
        n_res_valid = 1'b0;
        n_result    = '0;
        mem_we      = 1'b0;
        mem_addr    = here_addr;
        mem_wd      = CELL_BLANK;
        adv         = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                n_clr    = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                unique case (r_item.opcode)
                    OP_WRITE: begin
                        mem_we                 = item_ok;
                        mem_addr               = item_addr;
                        mem_wd                 = r_item.cell_value;
                        n_res_valid            = 1'b1;
                        n_result.address_error = !item_ok;
                        n_state                = S_IDLE;
                    end
                    OP_READ: begin
                        mem_addr = item_addr;
                        if (item_ok) begin
                            n_state = S_READ;
                        end else begin
                            n_res_valid            = 1'b1;
                            n_result.address_error = 1'b1;
                            n_state                = S_IDLE;
                        end
                    end
                    OP_ADVANCE: begin
                        if ((nr == '0) || (nc == '0)) begin
                            n_res_valid = 1'b1;
                            n_state     = S_IDLE;
                        end else begin
                            n_row   = ROW_W'(nr - ROWN_W'(1));
                            n_col   = '0;
                            n_skip  = 1'b0;
                            n_state = S_VISIT;
                        end
                    end
                    default: begin
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                n_res_valid         = 1'b1;
                n_result.read_value = r_mem_q;
                n_state             = S_IDLE;
            end
            S_VISIT: begin
                if (r_skip) begin
                    n_skip = 1'b0;
                    adv    = 1'b1;
                end else begin
                    n_state = S_KIND;
                end
            end
            S_KIND: begin
                if ((r_mem_q == CELL_SAND) || (r_mem_q == CELL_WATER)) begin
                    n_kind  = r_mem_q;
                    n_k     = K_BELOW;
                    n_state = S_CAND;
                end else begin
                    adv = 1'b1;
                end
            end
            S_CAND: begin
                if (r_k == tries) begin
                    adv = 1'b1;
                end else if (cand_ok) begin
                    mem_addr = cand_addr;
                    n_dest   = cand_addr;
                    n_state  = S_TEST;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_TEST: begin
                if (accept) begin
                    mem_we  = 1'b1;
                    mem_wd  = r_mem_q;
                    n_skip  = (r_k == K_RIGHT);
                    n_state = S_MOVE;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_CAND;
                end
            end
            S_MOVE: begin
                mem_we   = 1'b1;
                mem_addr = r_dest;
                mem_wd   = r_kind;
                adv      = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // step the sweep: left to right, rows bottom to top
        if (adv) begin
            n_state = S_VISIT;
            if (last_col) begin
                n_skip = 1'b0;
                n_col  = '0;
                if (r_row == '0) begin
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_row = r_row - ROW_W'(1);
                end
            end else begin
                n_col = col_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_mem_q <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rows      <= CFG_W'(256);
            r_cols      <= CFG_W'(256);
            r_skip      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_skip      <= n_skip;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_ACTIVE_ROWS: r_rows <= i_cfg_data;
                    REG_ACTIVE_COLS: r_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_row    <= n_row;
        r_col    <= n_col;
        r_k      <= n_k;
        r_kind   <= n_kind;
        r_dest   <= n_dest;
        r_result <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;
    assign o_cfg_ready    = (r_state == S_IDLE);

endmodule

// ----- verif/sand_grid_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sand_grid_checker: reply predictor and comparator for the falling-sand grid
// Watches the size register channel, the item handshake and the reply strobe.
// It keeps a shadow grid and works out each reply, including whole generation
// sweeps. Every strobed reply is compared field by field with the oldest one
// due. Failures and the number of replies still due are passed to the top.
// ----------------------------------------------------------------------------
module sand_grid_checker
    import fsgs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_item                i_item,
    input  logic                 i_result_valid,
    input  t_result              i_result,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [1:0]       shadow_grid [0:MAX_ROWS*MAX_COLS-1];
    bit               moved_mark  [0:MAX_ROWS*MAX_COLS-1];
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    t_result          replies_due [$];
    int               fails;

    function automatic int clip(input int n, input int lim);
        return (n > lim) ? lim : n;
    endfunction

    function automatic void sweep_generation();
        int         nr, nc, r, c, k, tr, tc, tries, here, dest, t;
        logic [1:0] kind, v;
        nr = clip(int'(rows_reg), MAX_ROWS);
        nc = clip(int'(cols_reg), MAX_COLS);
        for (r = 0; r < nr; r++)
            for (c = 0; c < nc; c++)
                moved_mark[r*MAX_COLS + c] = 1'b0;
        for (r = nr - 1; r >= 0; r--) begin
            for (c = 0; c < nc; c++) begin
                here = r*MAX_COLS + c;
                kind = shadow_grid[here];
                if (kind == CELL_BLANK || moved_mark[here])
                    continue;
                tries = (kind == CELL_SAND) ? 3 : (kind == CELL_WATER) ? 5 : 0;
                dest  = here;
                for (k = 0; k < tries; k++) begin
                    // below, below-left, below-right, left, right
                    tr = (k < 3) ? r + 1 : r;
                    case (k)
                        0:       tc = c;
                        1, 3:    tc = c - 1;
                        default: tc = c + 1;
                    endcase
                    if (tc < 0 || tr >= nr || tc >= nc)
                        continue;
                    t = tr*MAX_COLS + tc;
                    v = shadow_grid[t];
                    if (v == CELL_BLANK || (kind == CELL_SAND && v == CELL_WATER)) begin
                        dest = t;
                        break;
                    end
                end
                shadow_grid[here] = shadow_grid[dest];
                shadow_grid[dest] = kind;
                moved_mark[dest]  = 1'b1;
            end
        end
    endfunction

    function automatic t_result apply_item(input t_item it);
        t_result rep;
        bit      ok;
        rep = '0;
        ok  = (int'(it.row) < clip(int'(rows_reg), MAX_ROWS)) &&
              (int'(it.col) < clip(int'(cols_reg), MAX_COLS));
        case (it.opcode)
            OP_WRITE, OP_READ: begin
                if (!ok)
                    rep.address_error = 1'b1;
                else if (it.opcode == OP_WRITE)
                    shadow_grid[int'(it.row)*MAX_COLS + int'(it.col)] = it.cell_value;
                else
                    rep.read_value = shadow_grid[int'(it.row)*MAX_COLS + int'(it.col)];
            end
            OP_ADVANCE: sweep_generation();
            default: ;
        endcase
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int a = 0; a < MAX_ROWS*MAX_COLS; a++) begin
                shadow_grid[a] = CELL_BLANK;
                moved_mark[a]  = 1'b0;
            end
            rows_reg = 9'd256;
            cols_reg = 9'd256;
            replies_due.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ACTIVE_ROWS: rows_reg = i_cfg_data;
                    REG_ACTIVE_COLS: cols_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result_valid) begin
                if (replies_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("reply with none due: read_value %0d address_error %0d",
                                 i_result.read_value, i_result.address_error);
                end else begin
                    want = replies_due.pop_front();
                    if (i_result.read_value !== want.read_value ||
                        i_result.address_error !== want.address_error) begin
                        fails++;
                        if (fails <= 10)
                            $display("reply mismatch: read_value exp %0d got %0d, %s %0d got %0d",
                                     want.read_value, i_result.read_value,
                                     "address_error exp", want.address_error,
                                     i_result.address_error);
                    end
                end
            end
            if (i_start && !i_busy)
                replies_due.insert(replies_due.size(), apply_item(i_item));
        end
        o_pending    <= replies_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- verif/tb_falling_sand_grid_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_falling_sand_grid_step: stimulus and verdict for the falling-sand grid
// Drives cell writes, reads and generation steps under a range of grid sizes,
// from empty and single-row/column grids up to the full and oversized size,
// with random gaps between items. Replies are checked by sand_grid_checker.
// ----------------------------------------------------------------------------
module tb_falling_sand_grid_step;
    import fsgs_pkg::*;

    localparam logic [1:0]           OP_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int unsigned          CYCLE_LIMIT = 10_000_000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_item                i_item      = '0;
    logic                 o_result_valid;
    t_result              o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    int                   fail_count;
    int                   pending;
    int                   cur_rows    = 256;
    int                   cur_cols    = 256;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    falling_sand_grid_step uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    sand_grid_checker u_grid_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic t_item mk(input logic [1:0] op, input int r, input int c,
                                 input logic [1:0] v);
        t_item it;
        it.opcode     = op;
        it.row        = r[7:0];
        it.col        = c[7:0];
        it.cell_value = v;
        return it;
    endfunction

    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(3, 1);
        return $urandom_range(150, 20);
    endfunction

    task automatic issue_item(input t_item it, input bit calm);
        int gap;
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        gap = calm ? 0 : idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until the block is idle and every reply has arrived
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || pending != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        cfg_write(REG_ACTIVE_ROWS, rows);
        cfg_write(REG_ACTIVE_COLS, cols);
        cur_rows = (rows > MAX_ROWS) ? MAX_ROWS : int'(rows);
        cur_cols = (cols > MAX_COLS) ? MAX_COLS : int'(cols);
    endtask

    function automatic t_item random_item();
        int         pick, r, c;
        logic [1:0] op;
        bit         fits;
        pick = $urandom_range(99, 0);
        fits = (cur_rows > 0) && (cur_cols > 0);
        r    = $urandom_range(255, 0);
        c    = $urandom_range(255, 0);
        if (pick < 70 && fits) begin
            r = $urandom_range(cur_rows - 1, 0);
            c = $urandom_range(cur_cols - 1, 0);
        end
        if (pick < 45)
            op = OP_WRITE;
        else if (pick < 70)
            op = OP_READ;
        else if (pick < 82)
            op = OP_ADVANCE;
        else if (pick < 94)
            op = $urandom_range(1, 0) ? OP_WRITE : OP_READ;
        else
            op = OP_UNUSED;
        return mk(op, r, c, 2'($urandom_range(3, 0)));
    endfunction

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int               sent, n;
        logic [CFG_W-1:0] rows_w, cols_w;
        bit               calm;
        t_item            it;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // full grid, edges of both address fields, one generation
        issue_item(mk(OP_READ,    255, 255, CELL_BLANK), 1'b0);
        issue_item(mk(OP_WRITE,     0,   0, CELL_WATER), 1'b0);
        issue_item(mk(OP_WRITE,     0, 255, CELL_SAND),  1'b0);
        issue_item(mk(OP_WRITE,   255, 128, CELL_WOOD),  1'b0);
        issue_item(mk(OP_WRITE,   254, 128, CELL_SAND),  1'b0);
        issue_item(mk(OP_WRITE,   255, 255, CELL_SAND),  1'b0);
        issue_item(mk(OP_WRITE,   254, 255, CELL_WATER), 1'b0);
        issue_item(mk(OP_WRITE,   128, 127, CELL_BLANK), 1'b0);
        issue_item(mk(OP_UNUSED,  255, 255, CELL_WOOD),  1'b0);
        issue_item(mk(OP_ADVANCE, 170,  85, CELL_WATER), 1'b0);
        issue_item(mk(OP_READ,      0,   0, CELL_BLANK), 1'b0);
        issue_item(mk(OP_READ,      1,   0, CELL_BLANK), 1'b0);
        issue_item(mk(OP_READ,      0, 255, CELL_BLANK), 1'b0);
        issue_item(mk(OP_READ,      1, 255, CELL_BLANK), 1'b0);
        issue_item(mk(OP_READ,    255, 254, CELL_BLANK), 1'b0);
        issue_item(mk(OP_READ,    254, 128, CELL_BLANK), 1'b0);
        settle();

        // single row: row 1 is out of range
        set_size(9'd1, 9'd256);
        issue_item(mk(OP_READ,      0, 255, CELL_BLANK), 1'b0);
        issue_item(mk(OP_WRITE,     1,   0, CELL_SAND),  1'b0);
        issue_item(mk(OP_READ,      1,   0, CELL_BLANK), 1'b0);
        issue_item(mk(OP_ADVANCE,   0,   0, CELL_BLANK), 1'b0);
        settle();

        // empty grid
        set_size(9'd0, 9'd3);
        issue_item(mk(OP_READ,      0,   0, CELL_BLANK), 1'b0);
        issue_item(mk(OP_ADVANCE,   0,   0, CELL_BLANK), 1'b0);
        settle();

        // oversized registers clip to the full grid; spare indexes do nothing
        set_size(9'h1FF, 9'd300);
        cfg_write(REG_SPARE_2, 9'h1FF);
        cfg_write(REG_SPARE_3, 9'h0AA);
        issue_item(mk(OP_READ,    255, 255, CELL_BLANK), 1'b0);
        issue_item(mk(OP_WRITE,   255, 255, CELL_WOOD),  1'b0);
        settle();

        sent = 0;
        while (sent < 70) begin
            case ($urandom_range(9, 0))
                0: begin
                    rows_w = 9'd256;
                    cols_w = 9'($urandom_range(2, 1));
                end
                1: begin
                    rows_w = 9'($urandom_range(2, 1));
                    cols_w = 9'd256;
                end
                2: begin
                    rows_w = $urandom_range(1, 0) ? 9'd0 : 9'($urandom_range(8, 1));
                    cols_w = (rows_w == 0) ? 9'($urandom_range(8, 1)) : 9'd0;
                end
                3: begin
                    rows_w = 9'($urandom_range(511, 257));
                    cols_w = 9'($urandom_range(2, 1));
                end
                4: begin
                    rows_w = 9'($urandom_range(2, 1));
                    cols_w = 9'($urandom_range(511, 257));
                end
                default: begin
                    rows_w = 9'($urandom_range(12, 1));
                    cols_w = 9'($urandom_range(12, 1));
                end
            endcase
            set_size(rows_w, cols_w);
            calm = ($urandom_range(3, 0) == 0);
            n    = $urandom_range(20, 8);
            repeat (n) begin
                it = random_item();
                issue_item(it, calm);
                if (it.opcode != OP_UNUSED)
                    sent++;
            end
            settle();
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
